// File: src/virtio_mmio_transport_regs_assert.svh
// Assertion macros for the virtio-mmio register block checker.
`ifndef VIRTIO_MMIO_TRANSPORT_REGS_ASSERT_SVH
`define VIRTIO_MMIO_TRANSPORT_REGS_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VMT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define VMT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/vmt_pkg.sv
// Package: types, constants and status-write function of the virtio-mmio block.
`timescale 1ns / 1ps
package vmt_pkg;
    localparam int NumQueuesDef   = 2;
    localparam int MaxQueueLenDef = 256;

    localparam logic [31:0] MagicWord   = 32'h7472_6976;
    localparam logic [31:0] VersionWord = 32'd2;

    localparam logic [7:0] StAck       = 8'h01;
    localparam logic [7:0] StDriver    = 8'h02;
    localparam logic [7:0] StDriverOk  = 8'h04;
    localparam logic [7:0] StFeatOk    = 8'h08;
    localparam logic [7:0] StFailed    = 8'h80;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_IRQ   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_REG    = 2'd1,
        ERR_STATUS = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CFG_DEV_ID  = 2'd0,
        CFG_VENDOR  = 2'd1,
        CFG_FEATURE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [8:0]  reg_offset;
        logic [1:0]  access_size;
        logic [31:0] value;
    } item_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  error_code;
        logic        notify_pulse;
        logic [15:0] notified_queue;
        logic        reset_pulse;
        logic        irq_level;
    } item_out_t;

    // Status write outcome.
    typedef struct packed {
        logic [7:0] status;
        logic       bad;
    } stat_res_t;

    function automatic stat_res_t status_step(logic [7:0] cur, logic [31:0] data,
                                              logic feat_sub);
        stat_res_t   r;
        logic [7:0]  anded;
        logic [31:0] fresh;
        anded = cur & data[7:0];
        fresh = data ^ {24'd0, anded};
        r.status = anded;
        r.bad    = 1'b0;
        if (fresh == 32'd0) begin
        end else if (fresh == {24'd0, StAck}) begin
            if (anded == 8'd0) r.status = anded | StAck;
        end else if (fresh == {24'd0, StDriver}) begin
            if ((anded & StAck) != 8'd0) r.status = anded | StDriver;
        end else if (fresh == {24'd0, StFeatOk}) begin
            if (((anded & StDriver) != 8'd0) && feat_sub) r.status = anded | StFeatOk;
        end else if (fresh == {24'd0, StDriverOk}) begin
            r.status = anded | StDriverOk;
        end else if (fresh == {24'd0, StFailed}) begin
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction
endpackage

// File: src/virtio_mmio_transport_regs.sv
// Top level: virtio-mmio version 2 transport register block.
`timescale 1ns / 1ps
// Usage:
//  - Command channel: raise start with cmd (op, reg_offset, access_size,
//    value). A beat is taken at each clock edge with start high and busy
//    low; busy is always low, so one beat can be taken every cycle.
//  - Result channel: exactly one result beat per command, on rsp with
//    done high for one cycle, in the cycle after the command is taken.
//    The receiver cannot stall; results are never held back.
//  - Throughput 1 command per cycle: one decode and
//    update level between the state registers and the result register.
//  - Config port: cfg_we writes cfg_data to register cfg_index
//    (0 device id, 1 vendor, 2 offered features); write only while idle.
//  - Reset (rst_n low, async) clears all transport state; device id
//    resets to 1, vendor and features to 0.
//  - A status write of zero also clears transport state and pulses
//    reset_pulse in its result.
module virtio_mmio_transport_regs
    import vmt_pkg::*;
#(
    parameter int NUM_QUEUES    = NumQueuesDef,
    parameter int MAX_QUEUE_LEN = MaxQueueLenDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_in_t    cmd,
    output logic        done,
    output item_out_t   rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [31:0] dev_id_reg, vendor_reg;
    logic [63:0] offered_reg;
    logic [7:0]  status_reg, status_next;
    logic [31:0] dfsel_reg, dfsel_next, drvsel_reg, drvsel_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] qsel_reg, qsel_next;
    logic [1:0]  irq_reg, irq_next;
    logic        done_reg;
    item_out_t   rsp_reg, rsp_next;

    logic        take;
    logic [6:0]  word;
    logic [31:0] mask, data, rd;
    logic        qok, ready_rd, clr, qwr;
    stat_res_t   sres;

    assign busy = 1'b0;
    assign take = start;
    assign word = cmd.reg_offset[8:2];
    assign mask = (cmd.access_size == 2'd0) ? 32'h0000_00ff :
                  (cmd.access_size == 2'd1) ? 32'h0000_ffff : 32'hffff_ffff;
    assign data = cmd.value & mask;

    assign sres = status_step(status_reg, data, (acc_reg & ~offered_reg) == 64'd0);

    vmt_queue_file #(.NUM_QUEUES(NUM_QUEUES)) u_queues (
        .clk(clk), .rst_n(rst_n), .clr(clr), .wr_en(qwr), .word(word),
        .data(data), .sel(qsel_reg), .qok(qok), .ready_rd(ready_rd)
    );

    always_comb
    begin
        rd = 32'd0;
        rsp_next = '0;
        status_next = status_reg; dfsel_next = dfsel_reg; drvsel_next = drvsel_reg;
        acc_next = acc_reg; qsel_next = qsel_reg; irq_next = irq_reg;
        clr = 1'b0; qwr = 1'b0;
        if (take) begin
            case (op_t'(cmd.op))
                OP_READ:
                begin
                    if (word == 7'd0) rd = MagicWord;
                    else if (word == 7'd1) rd = VersionWord;
                    else if (word == 7'd2) rd = dev_id_reg;
                    else if (word == 7'd3) rd = vendor_reg;
                    else if (word == 7'd4) begin
                        if (dfsel_reg == 32'd0) rd = offered_reg[31:0];
                        else if (dfsel_reg == 32'd1) rd = offered_reg[63:32];
                    end
                    else if (word == 7'd13) rd = 32'(MAX_QUEUE_LEN);
                    else if (word >= 7'd17 && word <= 7'd19) rd = {31'd0, ready_rd};
                    else if (word == 7'd24) rd = {30'd0, irq_reg};
                    else if (word >= 7'd28 && word <= 7'd31) rd = {24'd0, status_reg};
                    else if (word == 7'd44 || word == 7'd45) rd = 32'hffff_ffff;
                    else if (word >= 7'd46) rd = 32'd0;
                    else rsp_next.error_code = ERR_REG;
                    rsp_next.read_data = rd & mask;
                end
                OP_WRITE:
                begin
                    if (word >= 7'd5 && word <= 7'd7) dfsel_next = data;
                    else if (word == 7'd8) begin
                        if (drvsel_reg == 32'd0) acc_next[31:0] = data;
                        else if (drvsel_reg == 32'd1) acc_next[63:32] = data;
                    end
                    else if (word >= 7'd9 && word <= 7'd11) drvsel_next = data;
                    else if (word == 7'd12) qsel_next = data[15:0];
                    else if ((word >= 7'd14 && word <= 7'd19) ||
                             (word >= 7'd32 && word <= 7'd42)) qwr = 1'b1;
                    else if (word >= 7'd20 && word <= 7'd23) begin
                        rsp_next.notify_pulse = 1'b1;
                        rsp_next.notified_queue = data[15:0];
                    end
                    else if (word >= 7'd25 && word <= 7'd27) irq_next = irq_reg & ~data[1:0];
                    else if (word >= 7'd28 && word <= 7'd31) begin
                        if (data == 32'd0) begin
                            clr = 1'b1;
                            rsp_next.reset_pulse = 1'b1;
                            status_next = '0; dfsel_next = '0; drvsel_next = '0;
                            acc_next = '0; qsel_next = '0; irq_next = '0;
                        end else begin
                            status_next = sres.status;
                            if (sres.bad) rsp_next.error_code = ERR_STATUS;
                        end
                    end
                    else if (word == 7'd43 || (word >= 7'd48 && word <= 7'd62) ||
                             word >= 7'd64) begin
                    end
                    else rsp_next.error_code = ERR_REG;
                end
                OP_IRQ: irq_next = irq_reg | cmd.value[1:0];
                default: ;
            endcase
        end
        rsp_next.irq_level = irq_next != 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dev_id_reg <= 32'd1; vendor_reg <= '0; offered_reg <= '0;
            status_reg <= '0; dfsel_reg <= '0; drvsel_reg <= '0;
            acc_reg <= '0; qsel_reg <= '0; irq_reg <= '0; done_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DEV_ID:  dev_id_reg  <= cfg_data[31:0];
                    CFG_VENDOR:  vendor_reg  <= cfg_data[31:0];
                    CFG_FEATURE: offered_reg <= cfg_data;
                    default: ;
                endcase
            end
            status_reg <= status_next; dfsel_reg <= dfsel_next; drvsel_reg <= drvsel_next;
            acc_reg <= acc_next; qsel_reg <= qsel_next; irq_reg <= irq_next;
            done_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;
endmodule

// File: src/vmt_queue_file.sv
// Per-queue state: size, ready flag and ring addresses, one lane per queue.
`timescale 1ns / 1ps
module vmt_queue_file
    import vmt_pkg::*;
#(
    parameter int NUM_QUEUES = NumQueuesDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr,
    input  logic        wr_en,
    input  logic [6:0]  word,
    input  logic [31:0] data,
    input  logic [15:0] sel,
    output logic        qok,
    output logic        ready_rd
);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic [15:0] len_reg   [NUM_QUEUES];
    logic        ready_reg [NUM_QUEUES];
    logic [63:0] desc_reg  [NUM_QUEUES];
    logic [63:0] avail_reg [NUM_QUEUES];
    logic [63:0] used_reg  [NUM_QUEUES];
    logic [QW-1:0] q;

    assign qok = sel < 16'(NUM_QUEUES);
    assign q   = qok ? sel[QW-1:0] : '0;
    assign ready_rd = qok ? ready_reg[q] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                len_reg[i] <= '0; ready_reg[i] <= 1'b0;
                desc_reg[i] <= '0; avail_reg[i] <= '0; used_reg[i] <= '0;
            end
        end else if (clr) begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                len_reg[i] <= '0; ready_reg[i] <= 1'b0;
                desc_reg[i] <= '0; avail_reg[i] <= '0; used_reg[i] <= '0;
            end
        end else if (wr_en && qok) begin
            if (word >= 7'd14 && word <= 7'd16) len_reg[q] <= data[15:0];
            if (word >= 7'd17 && word <= 7'd19 && data == 32'd1) ready_reg[q] <= 1'b1;
            if (word == 7'd32) desc_reg[q][31:0] <= data;
            if (word >= 7'd33 && word <= 7'd35) desc_reg[q][63:32] <= data;
            if (word == 7'd36) avail_reg[q][31:0] <= data;
            if (word >= 7'd37 && word <= 7'd39) avail_reg[q][63:32] <= data;
            if (word == 7'd40) used_reg[q][31:0] <= data;
            if (word >= 7'd41 && word <= 7'd42) used_reg[q][63:32] <= data;
        end
    end
endmodule

// File: src/vmt_checker.sv
// Port-level checker for the virtio-mmio register block, with bind.
`timescale 1ns / 1ps
`include "virtio_mmio_transport_regs_assert.svh"
module vmt_checker
    import vmt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input item_in_t  cmd,
    input logic      done,
    input item_out_t rsp
);
    `VMT_ASSERT_NXT(a_done_follows, clk, rst_n, start && !busy, done, "missing result beat")
    `VMT_ASSERT_NXT(a_no_spurious, clk, rst_n, !(start && !busy), !done, "spurious result beat")
    `VMT_ASSERT_IMP(a_err_range, clk, rst_n, done, rsp.error_code != 2'd3, "bad error code")
    `VMT_ASSERT_IMP(a_nq_zero, clk, rst_n, done && !rsp.notify_pulse,
        rsp.notified_queue == 16'd0, "queue index without notify")
endmodule

bind virtio_mmio_transport_regs vmt_checker u_vmt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
);

// File: tb/sv/testbench.sv
// Testbench for the virtio-mmio transport register block: directed and random bus beats.
`timescale 1ns / 1ps

// Predicts register-block results and checks them in order.
class regs_scoreboard;
    logic [31:0] dev_id;
    logic [31:0] vendor;
    logic [63:0] offered;
    logic [7:0]  status;
    logic [31:0] dev_sel;
    logic [31:0] drv_sel;
    logic [63:0] accepted;
    logic [15:0] qsel;
    logic [15:0] qlen [2];
    logic        qrdy [2];
    logic [63:0] desc_addr [2];
    logic [63:0] avail_addr [2];
    logic [63:0] used_addr [2];
    logic [1:0]  irq;
    vmt_pkg::item_out_t pending[$];
    int mismatches;
    int checked;

    function void clear_transport();
        status = 0; dev_sel = 0; drv_sel = 0; accepted = 0; qsel = 0; irq = 0;
        for (int i = 0; i < 2; i++) begin
            qlen[i] = 0; qrdy[i] = 0; desc_addr[i] = 0; avail_addr[i] = 0; used_addr[i] = 0;
        end
    endfunction

    function void power_on();
        dev_id = 1; vendor = 0; offered = 0; mismatches = 0; checked = 0;
        clear_transport();
    endfunction

    function void write_cfg(vmt_pkg::cfg_idx_t idx, logic [63:0] d);
        case (idx)
            vmt_pkg::CFG_DEV_ID:  dev_id = d[31:0];
            vmt_pkg::CFG_VENDOR:  vendor = d[31:0];
            vmt_pkg::CFG_FEATURE: offered = d;
            default: ;
        endcase
    endfunction

    // Status handshake: zero resets; else AND first, then the newly set bits decide.
    function logic [1:0] write_status(logic [31:0] d, output logic did_reset);
        logic [31:0] fresh;
        did_reset = 0;
        if (d == 0) begin
            clear_transport();
            did_reset = 1;
            return vmt_pkg::ERR_OK;
        end
        status = status & d[7:0];
        fresh = d ^ {24'd0, status};
        if (fresh == 0) return vmt_pkg::ERR_OK;
        if (fresh == {24'd0, vmt_pkg::StAck}) begin
            if (status == 0) status |= vmt_pkg::StAck;
        end else if (fresh == {24'd0, vmt_pkg::StDriver}) begin
            if (status & vmt_pkg::StAck) status |= vmt_pkg::StDriver;
        end else if (fresh == {24'd0, vmt_pkg::StFeatOk}) begin
            if ((status & vmt_pkg::StDriver) && ((accepted & ~offered) == 0))
                status |= vmt_pkg::StFeatOk;
        end else if (fresh == {24'd0, vmt_pkg::StDriverOk}) begin
            status |= vmt_pkg::StDriverOk;
        end else if (fresh != {24'd0, vmt_pkg::StFailed}) begin
            return vmt_pkg::ERR_STATUS;
        end
        return vmt_pkg::ERR_OK;
    endfunction

    function void note_beat(vmt_pkg::item_in_t c);
        vmt_pkg::item_out_t r;
        logic [6:0]  w;
        logic [31:0] mask, d;
        logic        ok, rst;
        int          q;
        w = c.reg_offset[8:2];
        mask = c.access_size == 0 ? 32'hff : (c.access_size == 1 ? 32'hffff : 32'hffff_ffff);
        d = c.value & mask;
        ok = qsel < 2;
        q = ok ? qsel : 0;
        r = '0;
        rst = 0;
        if (c.op == vmt_pkg::OP_READ) begin
            if (w == 0) r.read_data = vmt_pkg::MagicWord;
            else if (w == 1) r.read_data = vmt_pkg::VersionWord;
            else if (w == 2) r.read_data = dev_id;
            else if (w == 3) r.read_data = vendor;
            else if (w == 4) begin
                if (dev_sel == 0) r.read_data = offered[31:0];
                else if (dev_sel == 1) r.read_data = offered[63:32];
            end else if (w == 13) r.read_data = 32'd256;
            else if (w >= 17 && w <= 19) r.read_data = {31'd0, ok ? qrdy[q] : 1'b0};
            else if (w == 24) r.read_data = {30'd0, irq};
            else if (w >= 28 && w <= 31) r.read_data = {24'd0, status};
            else if (w == 44 || w == 45) r.read_data = 32'hffff_ffff;
            else if (w < 46) r.error_code = vmt_pkg::ERR_REG;
            r.read_data &= mask;
        end else if (c.op == vmt_pkg::OP_WRITE) begin
            if (w >= 5 && w <= 7) dev_sel = d;
            else if (w == 8) begin
                if (drv_sel == 0) accepted[31:0] = d;
                else if (drv_sel == 1) accepted[63:32] = d;
            end else if (w >= 9 && w <= 11) drv_sel = d;
            else if (w == 12) qsel = d[15:0];
            else if (w >= 14 && w <= 16) begin
                if (ok) qlen[q] = d[15:0];
            end else if (w >= 17 && w <= 19) begin
                if (ok && d == 1) qrdy[q] = 1;
            end else if (w >= 20 && w <= 23) begin
                r.notify_pulse = 1;
                r.notified_queue = d[15:0];
            end else if (w >= 25 && w <= 27) irq = irq & ~d[1:0];
            else if (w >= 28 && w <= 31) r.error_code = write_status(d, rst);
            else if (w == 32) begin
                if (ok) desc_addr[q][31:0] = d;
            end else if (w >= 33 && w <= 35) begin
                if (ok) desc_addr[q][63:32] = d;
            end else if (w == 36) begin
                if (ok) avail_addr[q][31:0] = d;
            end else if (w >= 37 && w <= 39) begin
                if (ok) avail_addr[q][63:32] = d;
            end else if (w == 40) begin
                if (ok) used_addr[q][31:0] = d;
            end else if (w >= 41 && w <= 42) begin
                if (ok) used_addr[q][63:32] = d;
            end else if (w == 43 || (w >= 48 && w <= 62) || w >= 64) begin
            end else r.error_code = vmt_pkg::ERR_REG;
        end else if (c.op == vmt_pkg::OP_IRQ) begin
            irq = irq | c.value[1:0];
        end
        r.reset_pulse = rst;
        r.irq_level = irq != 0;
        pending.push_back(r);
    endfunction

    function void check_beat(vmt_pkg::item_out_t got);
        vmt_pkg::item_out_t exp;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: rd %h/%h err %0d/%0d ntf %0d/%0d q %h/%h rst %0d/%0d irq %0d/%0d",
                         exp.read_data, got.read_data, exp.error_code, got.error_code,
                         exp.notify_pulse, got.notify_pulse, exp.notified_queue,
                         got.notified_queue, exp.reset_pulse, got.reset_pulse,
                         exp.irq_level, got.irq_level);
        end
    endfunction
endclass

module testbench;
    import vmt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_in_t    cmd;
    logic        done;
    item_out_t   rsp;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    regs_scoreboard sb;
    int idle_pct;
    int beats_sent;

    virtio_mmio_transport_regs uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off; just take each strobed beat.
    always @(posedge clk) begin
        if (rst_n && done) sb.check_beat(rsp);
    end

    // One bus beat; random idle cycles ahead of it per the current phase.
    task automatic send_beat(input op_t op, input logic [8:0] offs, input logic [1:0] sz,
                             input logic [31:0] val);
        item_in_t c;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        c.op = op; c.reg_offset = offs; c.access_size = sz; c.value = val;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_beat(c);
        beats_sent++;
    endtask

    // Drop start, let the queue of expected results drain plus latency.
    task automatic go_idle();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_cfg(idx, d);
    endtask

    task automatic wr(input int word, input logic [31:0] d);
        send_beat(OP_WRITE, 9'(word * 4), 2'd2, d);
    endtask

    task automatic rd(input int word);
        send_beat(OP_READ, 9'(word * 4), 2'd2, $urandom);
    endtask

    // Driver bring-up with random features (sometimes unoffered), queues and addresses.
    task automatic bring_up();
        wr(28, 32'd0); wr(28, 32'(StAck)); wr(28, 32'(StAck | StDriver));
        wr(9, 32'd0); wr(8, $urandom & sb.offered[31:0]);
        wr(9, 32'd1); wr(8, ($urandom_range(3) == 0) ? $urandom : ($urandom & sb.offered[63:32]));
        wr(28, 32'(StAck | StDriver | StFeatOk)); rd(28);
        for (int q = 0; q < 2; q++) begin
            wr(12, 32'(q)); rd(17); wr(14, $urandom_range(256));
            wr(32, $urandom); wr(33, $urandom); wr(36, $urandom); wr(37, $urandom);
            wr(40, $urandom); wr(41, $urandom); wr(17, 32'd1); rd(17);
        end
        wr(28, 32'(StAck | StDriver | StFeatOk | StDriverOk)); rd(28);
    endtask

    task automatic random_beat();
        int k;
        logic [31:0] v;
        k = $urandom_range(99);
        v = $urandom;
        if ($urandom_range(3) == 0) v = $urandom_range(3);
        if (k < 10) send_beat(OP_IRQ, 9'($urandom), 2'($urandom), v);
        else if (k < 13) send_beat(OP_NONE, 9'($urandom), 2'($urandom), v);
        else if (k < 45) send_beat(OP_READ, 9'($urandom), 2'($urandom), v);
        else if (k < 60) wr(28, 32'(1 << $urandom_range(7)) | {24'd0, sb.status});
        else if (k < 65) wr(20, v);
        else if (k < 70) wr(25, v);
        else send_beat(OP_WRITE, 9'($urandom), 2'($urandom), v);
    endtask

    initial begin
        int phase_pct [4] = '{0, 50, 0, 34};
        sb = new();
        sb.power_on();
        rst_n = 1'b0; start = 1'b0; cmd = '0; cfg_we = 1'b0; cfg_index = CFG_DEV_ID;
        cfg_data = '0; idle_pct = 0; beats_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fixed reads, sizes, errors, selects, irq, status cases.
        rd(0); rd(1); rd(2); rd(3); rd(4); rd(13); rd(44); rd(46); rd(64);
        send_beat(OP_READ, 9'h1ff, 2'd0, 32'hffff_ffff);
        send_beat(OP_READ, 9'h001, 2'd1, 32'd0);
        send_beat(OP_READ, 9'h014, 2'd3, 32'd0);  // write-only word read
        wr(0, 32'hffff_ffff);                  // read-only word write
        wr(5, 32'hffff_ffff); rd(4);
        wr(12, 32'h0001_0007); rd(17); wr(17, 32'd1);
        send_beat(OP_IRQ, 9'd0, 2'd0, 32'hffff_ffff); rd(24);
        wr(25, 32'd1); wr(28, 32'(StAck)); wr(28, 32'(StFeatOk)); wr(28, 32'h30);
        wr(28, 32'(StFailed | StAck)); wr(28, 32'd0);
        send_beat(OP_WRITE, 9'h050, 2'd0, 32'hffff_ffff);

        for (int p = 0; p < 4; p++) begin
            go_idle();
            case (p)
                0: begin
                    write_reg(CFG_DEV_ID, 64'hffff_ffff);
                    write_reg(CFG_VENDOR, 64'd0);
                    write_reg(CFG_FEATURE, 64'hffff_ffff_ffff_ffff);
                end
                1: begin
                    write_reg(CFG_DEV_ID, 64'd0);
                    write_reg(CFG_VENDOR, 64'hffff_ffff);
                    write_reg(CFG_FEATURE, 64'd0);
                end
                default: begin
                    write_reg(CFG_DEV_ID, 64'($urandom));
                    write_reg(CFG_VENDOR, 64'($urandom));
                    write_reg(CFG_FEATURE, {$urandom, $urandom});
                end
            endcase
            idle_pct = phase_pct[p];
            for (int n = 0; n < 180; n++) begin
                if ($urandom_range(59) == 0) bring_up();
                else random_beat();
            end
        end
        go_idle();
        repeat (5) @(posedge clk);

        $display("Covered %0d bus beats over four config/idle phases, %0d results checked.",
                 beats_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("virtio_mmio_transport_regs verification clean");
        else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("virtio_mmio_transport_regs verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out");
        $display("virtio_mmio_transport_regs verification failed");
        $finish;
    end
endmodule
